### rtl/wbps_pkg.sv
// Shared constants for the wildcard byte pattern search unit.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package wbps_pkg;

    // Field widths fixed by the block's interface
    localparam int DATA_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int WC_W        = 16;
    localparam int LEN_W       = 5;
    localparam int OUT_ADDR_W  = 32;
    localparam int OFFSET_W    = 32;
    localparam int PAT_BYTES   = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WC_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd4;

endpackage

`default_nettype wire

### rtl/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit.
// Depends on wbps_pkg for field widths and configuration register indexes.
`default_nettype none

// Streams the bytes of a memory region, one item per cycle, and reports the
// first place where the configured pattern (up to MAX_PATTERN bytes, each
// position optionally a wildcard) occurs. An item is taken in every cycle in
// which i_valid is high and o_stall is low; o_stall rises only while a
// finished result sits in the output register and the receiver stalls it.
// For each item the shift window is updated and all pattern
// positions are compared in parallel in the accepting cycle, and the result
// (found with the start address, or not found with address 0 on the
// region's last byte) appears in the output register on the next cycle.
// After a match the rest of the region is swallowed without results; the
// last byte of every region returns the fill count, offset and done flag to
// their starting values. The byte offset saturates at 2^32-1. Configuration
// writes (o_cfg_ready is always high) should be made while the unit is idle;
// they apply from the next item on.
module wildcard_byte_pattern_search_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // byte stream in
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [wbps_pkg::DATA_W-1:0]          i_data_byte,
    input  wire logic                                 i_last_byte,
    // result out
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic                                      o_found,
    output logic [wbps_pkg::OUT_ADDR_W-1:0]           o_match_address,
    // configuration writes
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int AW     = wbps_pkg::OUT_ADDR_W;
    localparam int LW     = wbps_pkg::LEN_W;
    // addresses wrap at 2^ADDR_BITS, then only the low 32 bits are reported
    localparam logic [AW-1:0] ADDR_MASK = (ADDR_BITS >= AW) ? {AW{1'b1}}
                                        : AW'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);
    localparam logic [wbps_pkg::OFFSET_W-1:0] OFFSET_MAX = '1;

    // configuration
    logic [wbps_pkg::CFG_DATA_W-1:0]   r_pat_low;
    logic [wbps_pkg::CFG_DATA_W-1:0]   r_pat_high;
    logic [wbps_pkg::WC_W-1:0]         r_wc_mask;
    logic [LW-1:0]                     r_pat_len;
    logic [AW-1:0]                     r_base;

    // scan state
    logic [wbps_pkg::DATA_W-1:0]       r_window [MAX_PATTERN];
    logic [wbps_pkg::DATA_W-1:0]       n_window [MAX_PATTERN];
    logic [FILL_W-1:0]                 r_fill;
    logic [FILL_W-1:0]                 n_fill;
    logic [wbps_pkg::OFFSET_W-1:0]     r_offset;
    logic                              r_done;

    // output register
    logic                              r_out_valid;
    logic                              r_out_found;
    logic [AW-1:0]                     r_out_addr;

    logic                              in_acc;
    logic                              out_acc;
    logic [LW-1:0]                     used_len;
    logic [2*wbps_pkg::CFG_DATA_W-1:0] pat_all;
    logic                              mismatch;
    logic                              match;
    logic [AW-1:0]                     start_off;
    logic [AW-1:0]                     n_addr;

    assign o_cfg_ready     = 1'b1;
    assign o_stall         = r_out_valid && i_stall;
    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_match_address = r_out_addr;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign pat_all = {r_pat_high, r_pat_low};

    // length register clamped into 1..MAX_PATTERN
    always_comb begin
        if (r_pat_len == '0) begin
            used_len = LW'(1);
        end else if (r_pat_len > LW'(MAX_PATTERN)) begin
            used_len = LW'(MAX_PATTERN);
        end else begin
            used_len = r_pat_len;
        end
    end

    // window after this byte is shifted in; newest byte at entry 0
    always_comb begin
        n_window[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_fill = (r_fill == FILL_MAX) ? r_fill : r_fill + FILL_W'(1);
    end

    // pattern byte i lines up with window entry len-1-i
    always_comb begin
        logic [LW-1:0] j;
        j        = '0;
        mismatch = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            j = used_len - LW'(1) - LW'(i);
            if ((LW'(i) < used_len) && !r_wc_mask[i] &&
                (n_window[j[IDX_W-1:0]] != pat_all[8*i +: 8])) begin
                mismatch = 1'b1;
            end
        end
        match = (LW'(n_fill) >= used_len) && !mismatch;
    end

    // start address of the match: offset of this byte minus (len - 1)
    assign start_off = r_offset - AW'(used_len - LW'(1));
    assign n_addr    = (r_base + start_off) & ADDR_MASK;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wc_mask  <= '0;
            r_pat_len  <= LW'(1);
            r_base     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wbps_pkg::CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                wbps_pkg::CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                wbps_pkg::CFG_WC_MASK:  r_wc_mask  <= i_cfg_data[wbps_pkg::WC_W-1:0];
                wbps_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[LW-1:0];
                wbps_pkg::CFG_BASE:     r_base     <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // window contents need no reset: entries beyond the fill count are never compared
    always_ff @(posedge i_clk) begin
        if (in_acc && !r_done) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

    // scan control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_offset    <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace the one leaving in the same cycle
            if (in_acc && !r_done && (match || i_last_byte)) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                if (i_last_byte) begin
                    // region end: back to a fresh scan
                    r_fill   <= '0;
                    r_offset <= '0;
                    r_done   <= 1'b0;
                end else if (!r_done) begin
                    r_fill <= n_fill;
                    if (r_offset != OFFSET_MAX) begin
                        r_offset <= r_offset + wbps_pkg::OFFSET_W'(1);
                    end
                    if (match) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge i_clk) begin
        if (in_acc && !r_done && (match || i_last_byte)) begin
            r_out_found <= match;
            r_out_addr  <= match ? n_addr : '0;
        end
    end

endmodule

`default_nettype wire

### rtl/wbps_checker.sv
// Port-level checks for the wildcard byte pattern search unit, with the bind.
// Depends on wbps_pkg and on the top level wildcard_byte_pattern_search_unit.
`default_nettype none

module wbps_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic                                 o_found,
    input wire logic [wbps_pkg::OUT_ADDR_W-1:0]      o_match_address
);

    // input side stalls only behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_match_address))
        else $error("stalled result changed");

    // not found always carries address zero
    a_miss_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_match_address == '0)
        else $error("not-found result with nonzero address");

    // a new result only follows an accepted item
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> $past(i_valid && !o_stall))
        else $error("result appeared without an accepted item");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_found         (o_found),
    .o_match_address (o_match_address)
);

`default_nettype wire
